// ===== rtl/ssd_pkg.sv =====
// ssd_pkg: shared widths and defaults for the 3d segment distance unit
// no dependencies; used by the top level, the quotient pipeline and the root pipeline
package ssd_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int IN_W = 32;
	localparam int THR_W = 16;
	localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);
	localparam int PARAM_W = 17;
	localparam int DIST_W = 35;
endpackage

// ===== rtl/ssd_div.sv =====
// ssd_div: pipelined clamped fraction num/den, one quotient bit per stage after the classify stage
// depends on ssd_pkg
module ssd_div #(
	parameter int FRAC_BITS = ssd_pkg::FRAC_BITS_DEF,
	parameter int NW = 2 * (2 * ssd_pkg::IN_W + 3 - ssd_pkg::FRAC_BITS_DEF) + 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic signed [NW-1:0]        num,
	input  logic signed [NW-1:0]        den,
	input  logic [ssd_pkg::THR_W-1:0]   thr,
	output logic                        out_valid,
	output logic [FRAC_BITS:0]          q
);
	localparam int ST = FRAC_BITS + 1;
	localparam logic [FRAC_BITS:0] ONE_Q = (FRAC_BITS + 1)'(1) << FRAC_BITS;

	logic [NW-1:0] rem_s [ST];
	logic [NW-1:0] den_s [ST];
	logic [FRAC_BITS-1:0] quo_s [ST];
	logic zero_s [ST];
	logic one_s [ST];
	logic vld_s [ST];
	logic signed [NW-1:0] thr_x;

	assign thr_x = $signed(NW'(thr));

	// classify: num < 0 or < thr, or den <= 0, gives zero; else num >= den gives one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0] <= num;
		den_s[0] <= den;
		quo_s[0] <= '0;
		zero_s[0] <= num[NW-1] || (num < thr_x) || den[NW-1] || (den == '0);
		one_s[0] <= !(num < den);
	end

	for (genvar i = 1; i < ST; i++) begin : g_step
		logic [NW-1:0] r2;
		logic ge;
		assign r2 = {rem_s[i-1][NW-2:0], 1'b0};
		assign ge = (r2 >= den_s[i-1]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else begin
				vld_s[i] <= vld_s[i-1];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[i] <= ge ? r2 - den_s[i-1] : r2;
			den_s[i] <= den_s[i-1];
			quo_s[i] <= {quo_s[i-1][FRAC_BITS-2:0], ge};
			zero_s[i] <= zero_s[i-1];
			one_s[i] <= one_s[i-1];
		end
	end

	assign out_valid = vld_s[ST-1];
	assign q = zero_s[ST-1] ? '0 : (one_s[ST-1] ? ONE_Q : {1'b0, quo_s[ST-1]});

	a_q_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> q <= ONE_Q)
		else $error("fraction above one");
endmodule

// ===== rtl/ssd_sqrt.sv =====
// ssd_sqrt: pipelined integer square root, one root bit per stage
// depends on ssd_pkg for the default width
module ssd_sqrt #(
	parameter int AW = 2 * (ssd_pkg::IN_W + ssd_pkg::FRAC_BITS_DEF + 2) + 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [AW-1:0]       rad,
	output logic                out_valid,
	output logic [AW/2-1:0]     root
);
	localparam int RW = AW / 2;

	logic [RW+1:0] rem_s [RW];
	logic [RW-1:0] root_s [RW];
	logic [AW-1:0] rad_s [RW];
	logic vld_s [RW];

	for (genvar i = 0; i < RW; i++) begin : g_step
		logic [RW+1:0] p_rem;
		logic [RW-1:0] p_root;
		logic [AW-1:0] p_rad;
		logic p_v;
		logic [RW+1:0] rem2;
		logic [RW+1:0] trial;
		logic ge;

		if (i == 0) begin : g_first
			assign p_rem = '0;
			assign p_root = '0;
			assign p_rad = rad;
			assign p_v = in_valid;
		end else begin : g_next
			assign p_rem = rem_s[i-1];
			assign p_root = root_s[i-1];
			assign p_rad = rad_s[i-1];
			assign p_v = vld_s[i-1];
		end

		assign rem2 = {p_rem[RW-1:0], p_rad[AW-1:AW-2]};
		assign trial = {p_root, 2'b01};
		assign ge = (rem2 >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else begin
				vld_s[i] <= p_v;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[i] <= ge ? rem2 - trial : rem2;
			root_s[i] <= {p_root[RW-2:0], ge};
			rad_s[i] <= {p_rad[AW-3:0], 2'b00};
		end
	end

	assign out_valid = vld_s[RW-1];
	assign root = root_s[RW-1];
endmodule

// ===== rtl/segment_segment_distance_3d_unit.sv =====
// segment_segment_distance_3d_unit: closest points and distance between two 3d segments
// depends on ssd_pkg, ssd_div, ssd_sqrt
//
//   channel   signals                          direction   handshake
//   config    cfg_valid cfg_ready cfg_data     in          valid and ready, ready always high
//   command   start busy + twelve coordinates  in          start while busy low
//   result    done first_param second_param    out         done strobe, one cycle
//             distance
//
// one item per clock
// items pass through the quotient pipeline (FRAC_BITS + 1 stages) and the
// square root pipeline (35 + FRAC_BITS stages, one root bit each)
// reset clears all valid bits and sets the threshold to 1
// busy never rises; results leave on done and cannot be held off
module segment_segment_distance_3d_unit #(
	parameter int FRAC_BITS = ssd_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ssd_pkg::THR_W-1:0]          cfg_data,
	input  logic                               start,
	output logic                               busy,
	input  logic signed [ssd_pkg::IN_W-1:0]    first_origin_x,
	input  logic signed [ssd_pkg::IN_W-1:0]    first_origin_y,
	input  logic signed [ssd_pkg::IN_W-1:0]    first_origin_z,
	input  logic signed [ssd_pkg::IN_W-1:0]    first_dir_x,
	input  logic signed [ssd_pkg::IN_W-1:0]    first_dir_y,
	input  logic signed [ssd_pkg::IN_W-1:0]    first_dir_z,
	input  logic signed [ssd_pkg::IN_W-1:0]    second_origin_x,
	input  logic signed [ssd_pkg::IN_W-1:0]    second_origin_y,
	input  logic signed [ssd_pkg::IN_W-1:0]    second_origin_z,
	input  logic signed [ssd_pkg::IN_W-1:0]    second_dir_x,
	input  logic signed [ssd_pkg::IN_W-1:0]    second_dir_y,
	input  logic signed [ssd_pkg::IN_W-1:0]    second_dir_z,
	output logic                               done,
	output logic [ssd_pkg::PARAM_W-1:0]        first_param,
	output logic [ssd_pkg::PARAM_W-1:0]        second_param,
	output logic [ssd_pkg::DIST_W-1:0]         distance
);
	localparam int IN_W = ssd_pkg::IN_W;
	localparam int PW2 = 2 * IN_W + 1;
	localparam int DW = 2 * IN_W + 3;
	localparam int VW = DW - FRAC_BITS;
	localparam int HW = (VW + 1) / 2;
	localparam int NW = 2 * VW + 1;
	localparam int DIV_LAT = FRAC_BITS + 1;
	localparam int SIDE_L = 7 + DIV_LAT;
	localparam int PW = IN_W + FRAC_BITS + 2;
	localparam int DFW = IN_W + FRAC_BITS + 3;
	localparam int MW2 = IN_W + FRAC_BITS + 2;
	localparam int H2 = (MW2 + 1) / 2;
	localparam int AW = 2 * MW2 + 2;
	localparam int RW = AW / 2;
	localparam int T_L = 4 + RW;
	localparam int LAT = 8 + DIV_LAT + 5 + RW + 1;

	localparam int D_A = 0;
	localparam int D_B = 1;
	localparam int D_C = 2;
	localparam int D_D = 3;
	localparam int D_E = 4;

	localparam int P_AC = 0;
	localparam int P_BB = 1;
	localparam int P_BE = 2;
	localparam int P_CD = 3;
	localparam int P_AE = 4;
	localparam int P_BD = 5;

	logic [ssd_pkg::THR_W-1:0] thr_q;
	logic signed [NW-1:0] thr_n;

	logic signed [IN_W-1:0] o0_in [3];
	logic signed [IN_W-1:0] d0_in [3];
	logic signed [IN_W-1:0] o1_in [3];
	logic signed [IN_W-1:0] d1_in [3];

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic v_s9, v_s10, v_s11, v_s12, v_s13;

	logic signed [IN_W-1:0] d0_s1 [3];
	logic signed [IN_W-1:0] d1_s1 [3];
	logic signed [IN_W:0] w_s1 [3];

	logic signed [PW2-1:0] dot_s2 [5][3];
	logic signed [DW-1:0] dsum [5];
	logic signed [VW-1:0] dv_s3 [5];

	logic signed [VW-1:0] op_a [6];
	logic signed [VW-1:0] op_b [6];
	logic [VW-1:0] ma [6];
	logic [VW-1:0] mb [6];
	logic [2*HW-1:0] pp_c [6][4];
	logic [2*HW-1:0] pp_s4 [6][4];
	logic sg_s4 [6];
	logic signed [VW-1:0] dv_s4 [5];

	logic [2*VW-1:0] pmag [6];
	logic signed [NW-1:0] prod_s5 [6];
	logic signed [VW-1:0] dv_s5 [5];

	logic signed [NW-1:0] denom_s6, snl_s6, tnl_s6;
	logic signed [VW-1:0] dv_s6 [5];

	logic signed [NW-1:0] sn_c7, sd_c7, tn_c7, td_c7;
	logic signed [NW-1:0] sn_s7, sd_s7, tn_s7, td_s7;
	logic signed [VW:0] nd_s7, nb_s7;
	logic signed [VW-1:0] a_s7;

	logic signed [NW-1:0] sn_c8, sd_c8, tn_c8, td_c8;
	logic signed [NW-1:0] sn_s8, sd_s8, tn_s8, td_s8;

	logic div0_v, div1_v, div_v;
	logic [FRAC_BITS:0] t0, t1;

	logic signed [IN_W-1:0] d0_dly_q [SIDE_L][3];
	logic signed [IN_W-1:0] d1_dly_q [SIDE_L][3];
	logic signed [IN_W:0] w_dly_q [SIDE_L][3];

	logic signed [PW-1:0] p0_s9 [3];
	logic signed [PW-1:0] p1_s9 [3];
	logic signed [IN_W:0] w_s9 [3];
	logic [FRAC_BITS:0] t0_s9, t1_s9;

	logic signed [DFW-1:0] df_s10 [3];

	logic [MW2-1:0] m_c [3];
	logic [2*H2-1:0] ll_s11 [3];
	logic [2*H2-1:0] lh_s11 [3];
	logic [2*H2-1:0] hh_s11 [3];

	logic [2*MW2-1:0] sq_s12 [3];
	logic [AW-1:0] acc_s13;

	logic sq_v;
	logic [RW-1:0] root;

	logic [FRAC_BITS:0] t0_dly_q [T_L];
	logic [FRAC_BITS:0] t1_dly_q [T_L];

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;
	assign thr_n = $signed(NW'(thr_q));

	assign o0_in[0] = first_origin_x;
	assign o0_in[1] = first_origin_y;
	assign o0_in[2] = first_origin_z;
	assign d0_in[0] = first_dir_x;
	assign d0_in[1] = first_dir_y;
	assign d0_in[2] = first_dir_z;
	assign o1_in[0] = second_origin_x;
	assign o1_in[1] = second_origin_y;
	assign o1_in[2] = second_origin_z;
	assign d1_in[0] = second_dir_x;
	assign d1_in[1] = second_dir_y;
	assign d1_in[2] = second_dir_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= ssd_pkg::THR_RESET;
		end else if (cfg_valid) begin
			thr_q <= cfg_data;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= div_v;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
			done <= sq_v;
		end
	end

	// origin difference; directions registered alongside
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			d0_s1[i] <= d0_in[i];
			d1_s1[i] <= d1_in[i];
			w_s1[i] <= (IN_W + 1)'(o0_in[i]) - (IN_W + 1)'(o1_in[i]);
		end
	end

	// dot product terms
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			dot_s2[D_A][i] <= PW2'(d0_s1[i]) * PW2'(d0_s1[i]);
			dot_s2[D_B][i] <= PW2'(d0_s1[i]) * PW2'(d1_s1[i]);
			dot_s2[D_C][i] <= PW2'(d1_s1[i]) * PW2'(d1_s1[i]);
			dot_s2[D_D][i] <= PW2'(d0_s1[i]) * PW2'(w_s1[i]);
			dot_s2[D_E][i] <= PW2'(d1_s1[i]) * PW2'(w_s1[i]);
		end
	end

	// dot sums, floored to the fixed scale
	always_comb begin
		for (int k = 0; k < 5; k++) begin
			dsum[k] = DW'(dot_s2[k][0]) + DW'(dot_s2[k][1]) + DW'(dot_s2[k][2]);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 5; k++) begin
			dv_s3[k] <= VW'(dsum[k] >>> FRAC_BITS);
		end
	end

	// wide products as four partial products
	always_comb begin
		op_a[P_AC] = dv_s3[D_A];
		op_b[P_AC] = dv_s3[D_C];
		op_a[P_BB] = dv_s3[D_B];
		op_b[P_BB] = dv_s3[D_B];
		op_a[P_BE] = dv_s3[D_B];
		op_b[P_BE] = dv_s3[D_E];
		op_a[P_CD] = dv_s3[D_C];
		op_b[P_CD] = dv_s3[D_D];
		op_a[P_AE] = dv_s3[D_A];
		op_b[P_AE] = dv_s3[D_E];
		op_a[P_BD] = dv_s3[D_B];
		op_b[P_BD] = dv_s3[D_D];
		for (int k = 0; k < 6; k++) begin
			ma[k] = op_a[k][VW-1] ? -op_a[k] : op_a[k];
			mb[k] = op_b[k][VW-1] ? -op_b[k] : op_b[k];
			pp_c[k][0] = (2 * HW)'(ma[k][HW-1:0]) * (2 * HW)'(mb[k][HW-1:0]);
			pp_c[k][1] = (2 * HW)'(ma[k][HW-1:0]) * (2 * HW)'(mb[k][VW-1:HW]);
			pp_c[k][2] = (2 * HW)'(ma[k][VW-1:HW]) * (2 * HW)'(mb[k][HW-1:0]);
			pp_c[k][3] = (2 * HW)'(ma[k][VW-1:HW]) * (2 * HW)'(mb[k][VW-1:HW]);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 6; k++) begin
			for (int j = 0; j < 4; j++) begin
				pp_s4[k][j] <= pp_c[k][j];
			end
			sg_s4[k] <= op_a[k][VW-1] ^ op_b[k][VW-1];
		end
		for (int k = 0; k < 5; k++) begin
			dv_s4[k] <= dv_s3[k];
		end
	end

	always_comb begin
		for (int k = 0; k < 6; k++) begin
			pmag[k] = (2 * VW)'(pp_s4[k][0])
				+ (((2 * VW)'(pp_s4[k][1]) + (2 * VW)'(pp_s4[k][2])) << HW)
				+ ((2 * VW)'(pp_s4[k][3]) << (2 * HW));
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 6; k++) begin
			prod_s5[k] <= sg_s4[k] ? -$signed({1'b0, pmag[k]}) : $signed({1'b0, pmag[k]});
		end
		for (int k = 0; k < 5; k++) begin
			dv_s5[k] <= dv_s4[k];
		end
	end

	// determinant and line numerators
	always_ff @(posedge clk) begin
		denom_s6 <= prod_s5[P_AC] - prod_s5[P_BB];
		snl_s6 <= prod_s5[P_BE] - prod_s5[P_CD];
		tnl_s6 <= prod_s5[P_AE] - prod_s5[P_BD];
		for (int k = 0; k < 5; k++) begin
			dv_s6[k] <= dv_s5[k];
		end
	end

	// parallel test and clamp of s to its edges
	always_comb begin
		if (denom_s6 < thr_n) begin
			sn_c7 = '0;
			sd_c7 = $signed(NW'(1) << (2 * FRAC_BITS));
			tn_c7 = NW'(dv_s6[D_E]);
			td_c7 = NW'(dv_s6[D_C]);
		end else begin
			sd_c7 = denom_s6;
			if (snl_s6 < 0) begin
				sn_c7 = '0;
				tn_c7 = NW'(dv_s6[D_E]);
				td_c7 = NW'(dv_s6[D_C]);
			end else if (snl_s6 > denom_s6) begin
				sn_c7 = denom_s6;
				tn_c7 = NW'(dv_s6[D_E]) + NW'(dv_s6[D_B]);
				td_c7 = NW'(dv_s6[D_C]);
			end else begin
				sn_c7 = snl_s6;
				tn_c7 = tnl_s6;
				td_c7 = denom_s6;
			end
		end
	end

	always_ff @(posedge clk) begin
		sn_s7 <= sn_c7;
		sd_s7 <= sd_c7;
		tn_s7 <= tn_c7;
		td_s7 <= td_c7;
		nd_s7 <= -(VW + 1)'(dv_s6[D_D]);
		nb_s7 <= (VW + 1)'(dv_s6[D_B]) - (VW + 1)'(dv_s6[D_D]);
		a_s7 <= dv_s6[D_A];
	end

	// clamp of t to its edges, s recomputed on that edge
	always_comb begin
		sn_c8 = sn_s7;
		sd_c8 = sd_s7;
		tn_c8 = tn_s7;
		td_c8 = td_s7;
		if (tn_s7 < 0) begin
			tn_c8 = '0;
			if (nd_s7 < 0) begin
				sn_c8 = '0;
			end else if (NW'(nd_s7) > NW'(a_s7)) begin
				sn_c8 = sd_s7;
			end else begin
				sn_c8 = NW'(nd_s7);
				sd_c8 = NW'(a_s7);
			end
		end else if (tn_s7 > td_s7) begin
			tn_c8 = td_s7;
			if (nb_s7 < 0) begin
				sn_c8 = '0;
			end else if (NW'(nb_s7) > NW'(a_s7)) begin
				sn_c8 = sd_s7;
			end else begin
				sn_c8 = NW'(nb_s7);
				sd_c8 = NW'(a_s7);
			end
		end
	end

	always_ff @(posedge clk) begin
		sn_s8 <= sn_c8;
		sd_s8 <= sd_c8;
		tn_s8 <= tn_c8;
		td_s8 <= td_c8;
	end

	ssd_div #(
		.FRAC_BITS(FRAC_BITS),
		.NW(NW)
	) u_div_s (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(v_s8),
		.num(sn_s8),
		.den(sd_s8),
		.thr(thr_q),
		.out_valid(div0_v),
		.q(t0)
	);

	ssd_div #(
		.FRAC_BITS(FRAC_BITS),
		.NW(NW)
	) u_div_t (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(v_s8),
		.num(tn_s8),
		.den(td_s8),
		.thr(thr_q),
		.out_valid(div1_v),
		.q(t1)
	);

	assign div_v = div0_v & div1_v;

	// directions and origin difference wait for the parameters
	always_ff @(posedge clk) begin
		for (int k = SIDE_L - 1; k > 0; k--) begin
			d0_dly_q[k] <= d0_dly_q[k-1];
			d1_dly_q[k] <= d1_dly_q[k-1];
			w_dly_q[k] <= w_dly_q[k-1];
		end
		d0_dly_q[0] <= d0_s1;
		d1_dly_q[0] <= d1_s1;
		w_dly_q[0] <= w_s1;
	end

	// closest point difference
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			p0_s9[i] <= PW'(d0_dly_q[SIDE_L-1][i]) * $signed(PW'(t0));
			p1_s9[i] <= PW'(d1_dly_q[SIDE_L-1][i]) * $signed(PW'(t1));
			w_s9[i] <= w_dly_q[SIDE_L-1][i];
		end
		t0_s9 <= t0;
		t1_s9 <= t1;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			df_s10[i] <= (DFW'(w_s9[i]) <<< FRAC_BITS) + DFW'(p0_s9[i]) - DFW'(p1_s9[i]);
		end
	end

	// squares as partial products
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			m_c[i] = df_s10[i][DFW-1] ? MW2'(-df_s10[i]) : MW2'(df_s10[i]);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			ll_s11[i] <= (2 * H2)'(m_c[i][H2-1:0]) * (2 * H2)'(m_c[i][H2-1:0]);
			lh_s11[i] <= (2 * H2)'(m_c[i][H2-1:0]) * (2 * H2)'(m_c[i][MW2-1:H2]);
			hh_s11[i] <= (2 * H2)'(m_c[i][MW2-1:H2]) * (2 * H2)'(m_c[i][MW2-1:H2]);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sq_s12[i] <= (2 * MW2)'(ll_s11[i])
				+ ((2 * MW2)'(lh_s11[i]) << (H2 + 1))
				+ ((2 * MW2)'(hh_s11[i]) << (2 * H2));
		end
	end

	always_ff @(posedge clk) begin
		acc_s13 <= AW'(sq_s12[0]) + AW'(sq_s12[1]) + AW'(sq_s12[2]);
	end

	ssd_sqrt #(
		.AW(AW)
	) u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(v_s13),
		.rad(acc_s13),
		.out_valid(sq_v),
		.root(root)
	);

	always_ff @(posedge clk) begin
		for (int k = T_L - 1; k > 0; k--) begin
			t0_dly_q[k] <= t0_dly_q[k-1];
			t1_dly_q[k] <= t1_dly_q[k-1];
		end
		t0_dly_q[0] <= t0_s9;
		t1_dly_q[0] <= t1_s9;
	end

	always_ff @(posedge clk) begin
		first_param <= ssd_pkg::PARAM_W'(t0_dly_q[T_L-1]);
		second_param <= ssd_pkg::PARAM_W'(t1_dly_q[T_L-1]);
		distance <= ssd_pkg::DIST_W'(root >> FRAC_BITS);
	end

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result without an item at the pipeline entry");

	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		div0_v == div1_v)
		else $error("quotient pipelines out of step");

	a_t_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		v_s8 |-> (tn_s8 == '0 || tn_s8 <= td_s8))
		else $error("t numerator not clamped");
endmodule
